FILE: rtl/core/mqsfp_pkg.sv
`default_nettype none

package mqsfp_pkg;

  // command codes
  typedef enum logic [2:0] {
    KIND_CREATE    = 3'd0,
    KIND_DESTROY   = 3'd1,
    KIND_ENQUEUE   = 3'd2,
    KIND_DEQUEUE   = 3'd3,
    KIND_NEXT_SLOT = 3'd4
  } kind_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NO_HANDLE  = 3'd1,
    ST_BAD_HANDLE = 3'd2,
    ST_FULL       = 3'd3,
    ST_EMPTY      = 3'd4,
    ST_BAD_SIZE   = 3'd5
  } status_t;

  // command sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_DESC,
    S_ORDER,
    S_DATA
  } state_t;

  // keep the low b bytes of a 64-bit word, all of it for eight or more
  function automatic logic [63:0] byte_mask(input logic [3:0] b);
    logic [63:0] m;
    for (int i = 0; i < 8; i++) begin
      m[8*i +: 8] = (b > 4'(i)) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/multi_queue_slot_fifo_pool_core.sv
// Pool of HANDLES slot buffers, each a ring of up to MAX_SLOTS data slots with a
// FIFO of filled slots. One command enters on the in_ channel (kind, handle,
// slot_count, slot_bytes, payload) and gives exactly one result on the out_
// channel (status, new_handle, slot_index, read_data, read_bytes).
// A transfer happens on a channel when valid is high and stall is low.
// Commands are handled one at a time: in_stall stays high from the transfer
// until the result is loaded into the output register.
// Create, destroy, enqueue, next_slot and an empty dequeue load their result
// from the descriptor step; a dequeue that finds data loads it after the
// descriptor read, queue order read and slot data read, each a registered RAM
// read. Any step that loads a result can wait for the output register.
// The next command is taken only after the last one's result is loaded.
// A new command is taken while the previous result still waits in the
// output register; a result is held until out_stall is low, and the next
// command then waits in its last step, with in_stall high, until the output
// register frees. Synchronous reset (rst_n low) frees every handle and empties
// the output register; the RAM contents need no clearing.
`default_nettype none

module multi_queue_slot_fifo_pool_core #(
  parameter int HANDLES    = 8,
  parameter int MAX_SLOTS  = 16,
  parameter int SLOT_BYTES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_kind,
  input  wire logic [2:0]  in_handle,
  input  wire logic [7:0]  in_slot_count,
  input  wire logic [3:0]  in_slot_bytes,
  input  wire logic [63:0] in_payload,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [2:0]       out_new_handle,
  output logic [3:0]       out_slot_index,
  output logic [63:0]      out_read_data,
  output logic [3:0]       out_read_bytes
);

  localparam int HW  = (HANDLES > 1) ? $clog2(HANDLES) : 1;
  localparam int SW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CW  = $clog2(MAX_SLOTS + 1);
  localparam int CW1 = CW + 1;
  localparam int BW  = $clog2(HANDLES + 1);
  localparam int AW  = HW + SW;

  typedef struct packed {
    logic [3:0]    bytes;
    logic [CW-1:0] slots;
    logic [SW-1:0] ring;
    logic [SW-1:0] head;
    logic [CW-1:0] fill;
  } desc_t;

  localparam int DW = $bits(desc_t);

  // control state
  mqsfp_pkg::state_t state_r, state_nxt;
  logic [HANDLES-1:0] in_use_r, in_use_nxt;
  logic [BW-1:0]      buffers_used_r, buffers_used_nxt;

  // latched command
  mqsfp_pkg::kind_t cmd_kind_r;
  logic [2:0]       cmd_handle_r;
  logic [7:0]       cmd_count_r;
  logic [3:0]       cmd_bytes_r;
  logic [63:0]      cmd_payload_r;
  logic [SW-1:0]    slot_p_r, slot_p_nxt;

  // output register
  logic                out_valid_r;
  mqsfp_pkg::status_t  out_status_r;
  logic [2:0]          out_new_handle_r;
  logic [3:0]          out_slot_index_r;
  logic [63:0]         out_read_data_r;
  logic [3:0]          out_read_bytes_r;

  // result to load
  logic                out_load;
  mqsfp_pkg::status_t  res_status;
  logic [2:0]          res_new_handle;
  logic [3:0]          res_slot_index;
  logic [63:0]         res_read_data;
  logic [3:0]          res_read_bytes;

  // ram ports
  logic          desc_wr_en, desc_rd_en;
  logic [HW-1:0] desc_wr_addr, desc_rd_addr;
  desc_t         desc_wr_data, desc_rd;
  logic [DW-1:0] desc_rd_bits;
  logic          order_wr_en, order_rd_en;
  logic [AW-1:0] order_wr_addr, order_rd_addr;
  logic [SW-1:0] order_wr_data, order_rd_data;
  logic          slot_wr_en, slot_rd_en;
  logic [AW-1:0] slot_wr_addr, slot_rd_addr;
  logic [63:0]   slot_wr_data, slot_rd_data;

  // decode helpers
  logic          in_accept;
  logic          out_free;
  logic [HW-1:0] hsel;
  logic          handle_ok;
  logic          free_found;
  logic [HW-1:0] free_idx;
  logic          size_bad;
  logic [CW-1:0] ring_inc;
  logic [SW-1:0] adv_p;
  logic [CW1-1:0] tail_sum;
  logic [SW-1:0] tail_p;
  logic [CW-1:0] head_inc;
  logic [SW-1:0] head_next;

  assign in_accept    = in_valid && !in_stall;
  assign out_free     = !out_valid_r || !out_stall;
  assign hsel         = HW'(cmd_handle_r);
  assign desc_rd      = desc_t'(desc_rd_bits);
  assign handle_ok    = (7'(cmd_handle_r) < 7'(HANDLES)) && in_use_r[hsel];
  assign size_bad     = (cmd_count_r == 8'd0) || (cmd_count_r > 8'(MAX_SLOTS)) ||
                        (cmd_bytes_r == 4'd0) || (cmd_bytes_r > 4'(SLOT_BYTES));

  // ring advance with wrap
  assign ring_inc = CW'(desc_rd.ring) + CW'(1);
  assign adv_p    = (desc_rd.slots == '0 || ring_inc >= desc_rd.slots) ? '0 : SW'(ring_inc);

  // queue tail: head is below the slot count and fill at most equal to it
  assign tail_sum = CW1'(desc_rd.head) + CW1'(desc_rd.fill);
  assign tail_p   = (tail_sum >= CW1'(desc_rd.slots)) ?
                    SW'(tail_sum - CW1'(desc_rd.slots)) : SW'(tail_sum);

  // head advance with wrap
  assign head_inc  = CW'(desc_rd.head) + CW'(1);
  assign head_next = (head_inc >= desc_rd.slots) ? '0 : SW'(head_inc);

  // lowest free handle
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = HANDLES - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        free_found = 1'b1;
        free_idx   = HW'(i);
      end
    end
  end

  // command latch
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_kind_r    <= mqsfp_pkg::kind_t'(in_kind);
      cmd_handle_r  <= in_handle;
      cmd_count_r   <= in_slot_count;
      cmd_bytes_r   <= in_slot_bytes;
      cmd_payload_r <= in_payload;
    end
    slot_p_r <= slot_p_nxt;
  end

  // state and handle bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= mqsfp_pkg::S_IDLE;
      in_use_r       <= '0;
      buffers_used_r <= '0;
    end else begin
      state_r        <= state_nxt;
      in_use_r       <= in_use_nxt;
      buffers_used_r <= buffers_used_nxt;
    end
  end

  // sequencer: next state, ram accesses and result
  always_comb begin
    state_nxt        = state_r;
    in_use_nxt       = in_use_r;
    buffers_used_nxt = buffers_used_r;
    slot_p_nxt       = slot_p_r;
    in_stall         = 1'b1;
    desc_rd_en       = 1'b0;
    desc_rd_addr     = HW'(in_handle);
    desc_wr_en       = 1'b0;
    desc_wr_addr     = hsel;
    desc_wr_data     = desc_rd;
    order_wr_en      = 1'b0;
    order_wr_addr    = {hsel, tail_p};
    order_wr_data    = adv_p;
    order_rd_en      = 1'b0;
    order_rd_addr    = {hsel, desc_rd.head};
    slot_wr_en       = 1'b0;
    slot_wr_addr     = {hsel, adv_p};
    slot_wr_data     = cmd_payload_r & mqsfp_pkg::byte_mask(desc_rd.bytes);
    slot_rd_en       = 1'b0;
    slot_rd_addr     = {hsel, order_rd_data};
    out_load         = 1'b0;
    res_status       = mqsfp_pkg::ST_OK;
    res_new_handle   = 3'd0;
    res_slot_index   = 4'd0;
    res_read_data    = 64'd0;
    res_read_bytes   = 4'd0;

    unique case (state_r)
      mqsfp_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          desc_rd_en = 1'b1;
          state_nxt  = mqsfp_pkg::S_DESC;
        end
      end

      mqsfp_pkg::S_DESC: begin
        if (cmd_kind_r == mqsfp_pkg::KIND_DEQUEUE && handle_ok &&
            desc_rd.fill != '0 && desc_rd.slots != '0) begin
          // pop the queue head, fetch its slot number
          order_rd_en       = 1'b1;
          desc_wr_en        = 1'b1;
          desc_wr_data.head = head_next;
          desc_wr_data.fill = desc_rd.fill - CW'(1);
          state_nxt         = mqsfp_pkg::S_ORDER;
        end else if (out_free) begin
          out_load  = 1'b1;
          state_nxt = mqsfp_pkg::S_IDLE;
          if (cmd_kind_r == mqsfp_pkg::KIND_CREATE) begin
            if (buffers_used_r >= BW'(HANDLES)) begin
              res_status = mqsfp_pkg::ST_NO_HANDLE;
            end else if (size_bad) begin
              res_status = mqsfp_pkg::ST_BAD_SIZE;
            end else if (!free_found) begin
              res_status = mqsfp_pkg::ST_NO_HANDLE;
            end else begin
              desc_wr_en           = 1'b1;
              desc_wr_addr         = free_idx;
              desc_wr_data.bytes   = cmd_bytes_r;
              desc_wr_data.slots   = CW'(cmd_count_r);
              desc_wr_data.ring    = '0;
              desc_wr_data.head    = '0;
              desc_wr_data.fill    = '0;
              in_use_nxt[free_idx] = 1'b1;
              buffers_used_nxt     = buffers_used_r + BW'(1);
              res_new_handle       = 3'(free_idx);
            end
          end else if (!handle_ok) begin
            res_status = mqsfp_pkg::ST_BAD_HANDLE;
          end else begin
            unique case (cmd_kind_r)
              mqsfp_pkg::KIND_DESTROY: begin
                in_use_nxt[hsel] = 1'b0;
                if (buffers_used_r != '0) begin
                  buffers_used_nxt = buffers_used_r - BW'(1);
                end
              end
              mqsfp_pkg::KIND_ENQUEUE: begin
                if (desc_rd.fill >= desc_rd.slots) begin
                  res_status = mqsfp_pkg::ST_FULL;
                end else begin
                  slot_wr_en        = 1'b1;
                  order_wr_en       = 1'b1;
                  desc_wr_en        = 1'b1;
                  desc_wr_data.ring = adv_p;
                  desc_wr_data.fill = desc_rd.fill + CW'(1);
                  res_slot_index    = 4'(adv_p);
                end
              end
              mqsfp_pkg::KIND_DEQUEUE: begin
                res_status = mqsfp_pkg::ST_EMPTY;
              end
              mqsfp_pkg::KIND_NEXT_SLOT: begin
                desc_wr_en        = 1'b1;
                desc_wr_data.ring = adv_p;
                res_slot_index    = 4'(adv_p);
              end
              default: begin
                res_status = mqsfp_pkg::ST_BAD_HANDLE;
              end
            endcase
          end
        end
      end

      mqsfp_pkg::S_ORDER: begin
        // fetch the slot data
        slot_rd_en = 1'b1;
        slot_p_nxt = order_rd_data;
        state_nxt  = mqsfp_pkg::S_DATA;
      end

      mqsfp_pkg::S_DATA: begin
        if (out_free) begin
          out_load       = 1'b1;
          res_slot_index = 4'(slot_p_r);
          res_read_data  = slot_rd_data;
          res_read_bytes = desc_rd.bytes;
          state_nxt      = mqsfp_pkg::S_IDLE;
        end
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r     <= res_status;
      out_new_handle_r <= res_new_handle;
      out_slot_index_r <= res_slot_index;
      out_read_data_r  <= res_read_data;
      out_read_bytes_r <= res_read_bytes;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_new_handle = out_new_handle_r;
  assign out_slot_index = out_slot_index_r;
  assign out_read_data  = out_read_data_r;
  assign out_read_bytes = out_read_bytes_r;

  // per-handle descriptors
  mqsfp_ram #(
    .WIDTH (DW),
    .DEPTH (1 << HW)
  ) u_desc_ram (
    .clk     (clk),
    .wr_en   (desc_wr_en),
    .wr_addr (desc_wr_addr),
    .wr_data (desc_wr_data),
    .rd_en   (desc_rd_en),
    .rd_addr (desc_rd_addr),
    .rd_data (desc_rd_bits)
  );

  // queue order of filled slots
  mqsfp_ram #(
    .WIDTH (SW),
    .DEPTH (1 << AW)
  ) u_order_ram (
    .clk     (clk),
    .wr_en   (order_wr_en),
    .wr_addr (order_wr_addr),
    .wr_data (order_wr_data),
    .rd_en   (order_rd_en),
    .rd_addr (order_rd_addr),
    .rd_data (order_rd_data)
  );

  // slot data
  mqsfp_ram #(
    .WIDTH (64),
    .DEPTH (1 << AW)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (slot_wr_en),
    .wr_addr (slot_wr_addr),
    .wr_data (slot_wr_data),
    .rd_en   (slot_rd_en),
    .rd_addr (slot_rd_addr),
    .rd_data (slot_rd_data)
  );

  // handle count tracks the allocation bits
  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    buffers_used_r == BW'($countones(in_use_r)))
    else $error("buffer count differs from allocated handles");

  // an accepted command always reads its descriptor next
  a_accept_desc: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> state_r == mqsfp_pkg::S_DESC)
    else $error("accepted command did not go to descriptor state");

  // results come only from the descriptor or data states
  a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (state_r == mqsfp_pkg::S_DESC || state_r == mqsfp_pkg::S_DATA))
    else $error("result loaded from wrong state");

  // the order read step is always followed by the data read step
  a_order_seq: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mqsfp_pkg::S_ORDER |=> state_r == mqsfp_pkg::S_DATA)
    else $error("order read not followed by data read");

endmodule

`default_nettype wire

FILE: rtl/core/mqsfp_ram.sv
`default_nettype none

module mqsfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic                                   rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
